FILE: design/rsbk_pkg.sv
// Package for the record sorter: sizes, word types, state encoding and key mapping.
package rsbk_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	typedef struct packed {
		logic [31:0]        key_x;
		logic [31:0]        coord_y;
		logic [31:0]        hit_id;
		logic signed [31:0] coord_z;
		logic               last;
	} rec_in_t;

	typedef struct packed {
		logic [31:0]        out_x;
		logic [31:0]        out_y;
		logic [31:0]        out_id;
		logic signed [31:0] out_z;
		logic               out_last;
		logic               overflow;
	} rec_out_t;

	// one stored record
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] id;
		logic [31:0] z;
	} mem_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT
	} st_t;

	// IEEE single bit pattern to an unsigned key with float ordering, -0 folded to +0
	function automatic logic [31:0] order_key(input logic [31:0] bits);
		logic [31:0] b;
		b = (bits == 32'h8000_0000) ? 32'h0000_0000 : bits;
		if (b[31]) begin
			return ~b;
		end
		return b | 32'h8000_0000;
	endfunction

endpackage

FILE: design/record_sort_by_key.sv
// Record sorter: collects a segment of hit records and emits it in ascending float x order.
//
// Records arrive as words on the rec channel and are kept in a record memory with separate
// write and read ports (MAX_RECORDS deep, one write and one registered read per cycle) in
// sorted order. Each arriving record is placed by an insertion loop: one shared key
// comparator walks down from the top of the stored run, moving one greater-keyed record up
// by one slot per cycle. A record into an empty store goes straight into slot zero, and one
// that arrives while the store is full is dropped. rec_ready is low while a record is being
// placed. Keys compare as IEEE single values with -0 equal to +0; equal keys leave in
// arrival order. The word with last set closes the segment: after its placement the
// ST_EMIT_RD state primes the memory read, then the sorted run leaves on the sorted channel
// at one word per cycle while sorted_ready is high. out_last marks the final word of the
// run; overflow is set on every word of a run whose segment lost records to a full store
// (records beyond capacity, including one carrying last, are dropped, but last still
// closes the segment). After the last word the store is empty again. No clearing pass is
// needed after reset.
module record_sort_by_key
	import rsbk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rec_valid,
	output logic     rec_ready,
	input  rec_in_t  rec,
	output logic     sorted_valid,
	input  logic     sorted_ready,
	output rec_out_t sorted
);

	// record memory
	mem_rec_t mem_q [MAX_RECORDS];
	mem_rec_t rd_q;

	// control state
	st_t             st_q, st_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             drop_q, drop_d;

	// the record being placed (payload, no reset)
	mem_rec_t rec_q;
	logic     last_q;

	// memory port controls
	logic             we;
	logic [IDX_W-1:0] waddr;
	mem_rec_t         wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;

	logic     accept;
	logic     full;
	logic     greater;
	logic     run_end;
	mem_rec_t in_rec;

	assign accept  = rec_valid && rec_ready;
	assign full    = (cnt_q == CNT_W'(MAX_RECORDS));
	assign in_rec  = '{x: rec.key_x, y: rec.coord_y, id: rec.hit_id, z: rec.coord_z};
	// the shared comparator: stored neighbor vs record being placed
	assign greater = order_key(rd_q.x) > order_key(rec_q.x);
	assign run_end = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	always_comb begin
		st_d   = st_q;
		cnt_d  = cnt_q;
		pos_d  = pos_q;
		idx_d  = idx_q;
		drop_d = drop_q;
		we     = 1'b0;
		waddr  = IDX_W'(pos_q);
		wdata  = rec_q;
		re     = 1'b0;
		raddr  = IDX_W'(pos_q - CNT_W'(1));
		rec_ready    = 1'b0;
		sorted_valid = 1'b0;
		case (st_q)
			ST_IDLE: begin
				rec_ready = 1'b1;
				if (rec_valid) begin
					if (full) begin
						drop_d = 1'b1;
						if (rec.last) begin
							idx_d = '0;
							st_d  = ST_EMIT_RD;
						end
					end else if (cnt_q == '0) begin
						// empty store: straight into slot zero
						we    = 1'b1;
						waddr = '0;
						wdata = in_rec;
						cnt_d = CNT_W'(1);
						if (rec.last) begin
							idx_d = '0;
							st_d  = ST_EMIT_RD;
						end
					end else begin
						pos_d = cnt_q;
						re    = 1'b1;
						raddr = IDX_W'(cnt_q - CNT_W'(1));
						st_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (greater) begin
					// move neighbor up one slot
					we    = 1'b1;
					waddr = IDX_W'(pos_q);
					wdata = rd_q;
					pos_d = pos_q - CNT_W'(1);
					if (pos_q == CNT_W'(1)) begin
						st_d = ST_PLACE;
					end else begin
						re    = 1'b1;
						raddr = IDX_W'(pos_q - CNT_W'(2));
					end
				end else begin
					we    = 1'b1;
					waddr = IDX_W'(pos_q);
					wdata = rec_q;
					cnt_d = cnt_q + CNT_W'(1);
					idx_d = '0;
					st_d  = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_PLACE: begin
				we    = 1'b1;
				waddr = IDX_W'(pos_q);
				wdata = rec_q;
				cnt_d = cnt_q + CNT_W'(1);
				idx_d = '0;
				st_d  = last_q ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				re    = 1'b1;
				raddr = idx_q;
				st_d  = ST_EMIT;
			end
			ST_EMIT: begin
				sorted_valid = 1'b1;
				if (sorted_ready) begin
					if (run_end) begin
						cnt_d  = '0;
						drop_d = 1'b0;
						st_d   = ST_IDLE;
					end else begin
						// fetch the next word while this one leaves
						idx_d = idx_q + IDX_W'(1);
						re    = 1'b1;
						raddr = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// output word straight from the registered read data
	assign sorted = '{
		out_x:    rd_q.x,
		out_y:    rd_q.y,
		out_id:   rd_q.id,
		out_z:    signed'(rd_q.z),
		out_last: run_end,
		overflow: drop_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			pos_q  <= '0;
			idx_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			pos_q  <= pos_d;
			idx_q  <= idx_d;
			drop_q <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q  <= in_rec;
			last_q <= rec.last;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECORDS))
		else $error("record count above capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid |-> (cnt_q != '0) && (CNT_W'(idx_q) < cnt_q))
		else $error("emitting from an empty or exhausted run");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> full)
		else $error("drop flag set while store not full");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN || st_q == ST_PLACE) |-> (pos_q <= cnt_q) && !full)
		else $error("insertion position out of range");

	a_sorted_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted_valid && sorted_ready && !run_end)
		|=> order_key(rd_q.x) >= $past(order_key(rd_q.x)))
		else $error("sorted run not ascending");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for record_sort_by_key: directed and random segments checked against a sorting model.
module tb_top
	import rsbk_pkg::*;
();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, enough to back up the input
	localparam int RAND_ITEMS   = 86;
	localparam int GAP_MAX      = 18;

	// Sorting model: keeps the open segment in x order and, when a word with last arrives,
	// turns the whole segment into the queue of sorted words the block must send out.
	class segment_sorter;
		mem_rec_t    held[MAX_RECORDS];
		int unsigned held_cnt;
		bit          lost;
		rec_out_t    sorted_run_q[$];
		int unsigned errors;

		function new();
			held_cnt = 0;
			lost     = 0;
			errors   = 0;
		endfunction

		// a > b as IEEE single values; -0 folded onto +0. NaNs fall outside the
		// infinities by magnitude, which also gives their bit-pattern order.
		static function bit x_above(logic [31:0] a, logic [31:0] b);
			logic [31:0] fa;
			logic [31:0] fb;
			fa = (a == 32'h8000_0000) ? 32'h0 : a;
			fb = (b == 32'h8000_0000) ? 32'h0 : b;
			if (fa[31] != fb[31]) begin
				return !fa[31];
			end
			if (!fa[31]) begin
				return fa[30:0] > fb[30:0];
			end
			return fa[30:0] < fb[30:0];
		endfunction

		function void place_record(rec_in_t w);
			int unsigned pos;
			rec_out_t    o;
			if (held_cnt < MAX_RECORDS) begin
				// strict compare: equal keys stay behind earlier arrivals
				pos = held_cnt;
				while (pos > 0 && x_above(held[pos - 1].x, w.key_x)) begin
					held[pos] = held[pos - 1];
					pos--;
				end
				held[pos].x  = w.key_x;
				held[pos].y  = w.coord_y;
				held[pos].id = w.hit_id;
				held[pos].z  = w.coord_z;
				held_cnt++;
			end else begin
				lost = 1;   // store full: dropped, even when it carries last
			end
			if (w.last) begin
				for (int i = 0; i < held_cnt; i++) begin
					o.out_x    = held[i].x;
					o.out_y    = held[i].y;
					o.out_id   = held[i].id;
					o.out_z    = held[i].z;
					o.out_last = (i == held_cnt - 1);
					o.overflow = lost;
					sorted_run_q.push_back(o);
				end
				held_cnt = 0;
				lost     = 0;
			end
		endfunction

		function void check_sorted_word(rec_out_t got);
			rec_out_t exp;
			if (sorted_run_q.size() == 0) begin
				$error("sorted word with nothing expected: x %h id %h", got.out_x, got.out_id);
				errors++;
				return;
			end
			exp = sorted_run_q.pop_front();
			if (got.out_x !== exp.out_x) begin
				$error("out_x: expected %h, got %h", exp.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp.out_y) begin
				$error("out_y: expected %h, got %h", exp.out_y, got.out_y);
				errors++;
			end
			if (got.out_id !== exp.out_id) begin
				$error("out_id: expected %h, got %h", exp.out_id, got.out_id);
				errors++;
			end
			if (got.out_z !== exp.out_z) begin
				$error("out_z: expected %0d, got %0d", exp.out_z, got.out_z);
				errors++;
			end
			if (got.out_last !== exp.out_last) begin
				$error("out_last: expected %b, got %b", exp.out_last, got.out_last);
				errors++;
			end
			if (got.overflow !== exp.overflow) begin
				$error("overflow: expected %b, got %b", exp.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     rec_valid;
	logic     rec_ready;
	rec_in_t  rec;
	logic     sorted_valid;
	logic     sorted_ready;
	rec_out_t sorted;

	segment_sorter board = new();
	int unsigned   cycle_cnt;
	int unsigned   id_seq;
	bit            hold_req;   // asks the receiver for one long hold-off

	record_sort_by_key DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec_ready    (rec_ready),
		.rec          (rec),
		.sorted_valid (sorted_valid),
		.sorted_ready (sorted_ready),
		.sorted       (sorted)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one record word after a random gap; valid stays up until accepted.
	// Back-to-back words keep valid high, so valid gets one assignment per edge.
	task automatic send_record(rec_in_t w, int gap_max);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_valid <= 1'b1;
		rec       <= w;
		do @(posedge clk); while (!rec_ready);
		board.place_record(w);
	endtask

	// directed word: chosen key, traceable id, random payload
	task automatic send_directed(logic [31:0] x, bit last, int gap_max);
		rec_in_t w;
		w.key_x   = x;
		w.coord_y = $urandom();
		w.hit_id  = id_seq++;
		w.coord_z = $urandom();
		w.last    = last;
		send_record(w, gap_max);
	endtask

	// Random keys: mostly arbitrary patterns, plus a pool of repeats for ties,
	// signed zeros, infinities and the odd NaN.
	function automatic logic [31:0] rand_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: k = 32'h0000_0000;
					1: k = 32'h8000_0000;
					2: k = 32'h7F80_0000;
					3: k = 32'hFF80_0000;
					4: k = 32'h3F80_0000;
					default: k = 32'hBF80_0000;
				endcase
			end
			1: k = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom())};
			2, 3: k = {1'($urandom_range(0, 1)), 31'h4000_0000 | (31'($urandom_range(0, 3)) << 20)};
			4: k = {1'($urandom_range(0, 1)), 8'h00, 23'($urandom_range(0, 7))};
			default: k = $urandom();
		endcase
		return k;
	endfunction

	// Receiver: random stall before each word, with runs of no stalling, and one
	// long hold-off on request so the block backs up into its input.
	initial begin : sink
		int stall;
		int sink_max;
		sink_max = GAP_MAX;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				sink_max = (sink_max == 0) ? GAP_MAX : 0;
			end
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = $urandom_range(0, sink_max);
			end
			if (stall > 0) begin
				sorted_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sorted_ready <= 1'b1;
			do @(posedge clk); while (!sorted_valid);
			board.check_sorted_word(sorted);
		end
	end

	initial begin
		int      seg_no;
		int      len;
		int      gap_max;
		int      rand_sent;
		rec_in_t w;

		arst_n       = 1'b0;
		rec_valid    = 1'b0;
		rec          = '0;
		sorted_ready = 1'b0;
		hold_req     = 1'b0;
		id_seq       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// single-record run
		send_directed(32'h3F80_0000, 1'b1, GAP_MAX);

		// payload extremes: all ones (a negative NaN key) and all zeros, z at its signed max and min
		w = '{key_x: 32'hFFFF_FFFF, coord_y: 32'hFFFF_FFFF, hit_id: 32'hFFFF_FFFF,
		      coord_z: 32'sh7FFF_FFFF, last: 1'b0};
		send_record(w, GAP_MAX);
		w = '{key_x: 32'h0, coord_y: 32'h0, hit_id: 32'h0, coord_z: 32'sh8000_0000,
		      last: 1'b1};
		send_record(w, 0);

		// signed zeros tie and must keep arrival order
		send_directed(32'h0000_0000, 1'b0, 0);
		send_directed(32'h8000_0000, 1'b0, 0);
		send_directed(32'hBF80_0000, 1'b0, GAP_MAX);
		send_directed(32'h8000_0000, 1'b0, 0);
		send_directed(32'h0000_0000, 1'b0, GAP_MAX);
		send_directed(32'h3F80_0000, 1'b1, 0);

		// infinities, NaNs of both signs, denormals, largest finite values
		send_directed(32'h7F80_0000, 1'b0, 0);
		send_directed(32'hFF80_0000, 1'b0, 0);
		send_directed(32'h7FC0_0000, 1'b0, GAP_MAX);
		send_directed(32'h0000_0001, 1'b0, 0);
		send_directed(32'hFFC0_0000, 1'b0, 0);
		send_directed(32'h8000_0001, 1'b0, GAP_MAX);
		send_directed(32'h7F7F_FFFF, 1'b0, 0);
		send_directed(32'h7FC0_0000, 1'b0, 0);
		send_directed(32'hFF7F_FFFF, 1'b0, 0);
		send_directed(32'h7F80_0001, 1'b1, GAP_MAX);

		// strictly descending keys: every record walks to the bottom
		send_directed(32'h4040_0000, 1'b0, 0);
		send_directed(32'h4000_0000, 1'b0, 0);
		send_directed(32'h3F80_0000, 1'b0, 0);
		send_directed(32'h0000_0000, 1'b0, 0);
		send_directed(32'hC000_0000, 1'b1, 0);

		// random segments; the third fills the store and overruns it
		seg_no    = 0;
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			if (seg_no == 2) begin
				len = MAX_RECORDS + $urandom_range(1, 3);
			end else begin
				len = $urandom_range(1, 12);
			end
			if (seg_no == 2) begin
				hold_req = 1'b1;
			end
			// some segments arrive as a solid burst
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			for (int k = 0; k < len; k++) begin
				w.key_x   = rand_key();
				w.coord_y = $urandom();
				w.hit_id  = $urandom();
				w.coord_z = $urandom();
				w.last    = (k == len - 1);
				send_record(w, gap_max);
			end
			rand_sent += len;
			seg_no++;
		end
		rec_valid <= 1'b0;

		while (board.sorted_run_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
